// ===== rtl/fired_tile_event_set_macros.svh =====
// assertion helpers, sampled on clk, off during reset
`ifndef FIRED_TILE_EVENT_SET_MACROS_SVH
`define FIRED_TILE_EVENT_SET_MACROS_SVH

`define FTE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define FTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fte_pkg.sv =====
package fte_pkg;

	localparam int SET_ENTRIES = 8;
	localparam int CNT_W = $clog2(SET_ENTRIES + 1);
	localparam int IDX_W = (SET_ENTRIES > 1) ? $clog2(SET_ENTRIES) : 1;
	localparam int COORD_W = 16;
	localparam int ENTRY_W = 2 * COORD_W;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_QUERY = 2'd2
	} fte_mode_t;

	typedef struct packed {
		logic [1:0]                 mode;
		logic [31:0]                region_id;
		logic signed [COORD_W-1:0] tile_col;
		logic signed [COORD_W-1:0] tile_row;
		logic signed [COORD_W-1:0] rect_left;
		logic signed [COORD_W-1:0] rect_top;
		logic signed [COORD_W-1:0] rect_right;
		logic signed [COORD_W-1:0] rect_bottom;
	} fte_item_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic finish;
	} fte_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_busy;
	} fte_sts_t;

endpackage

// ===== rtl/fte_if.sv =====
interface fte_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [31:0]        region_id;
	logic signed [15:0] tile_col;
	logic signed [15:0] tile_row;
	logic signed [15:0] rect_left;
	logic signed [15:0] rect_top;
	logic signed [15:0] rect_right;
	logic signed [15:0] rect_bottom;

	modport source (
		output valid, mode, region_id, tile_col, tile_row,
		output rect_left, rect_top, rect_right, rect_bottom,
		input  ready
	);
	modport sink (
		input  valid, mode, region_id, tile_col, tile_row,
		input  rect_left, rect_top, rect_right, rect_bottom,
		output ready
	);
endinterface

interface fte_rsp_if;
	logic       valid;
	logic       ready;
	logic       in_rect;
	logic [3:0] entry_count;

	modport source (
		output valid, in_rect, entry_count,
		input  ready
	);
	modport sink (
		input  valid, in_rect, entry_count,
		output ready
	);
endinterface

// ===== rtl/fte_ram.sv =====
module fte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/fte_dp.sv =====
`include "fired_tile_event_set_macros.svh"

module fte_dp import fte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fte_cmd_t  cmd,
	output fte_sts_t  sts,
	input  fte_item_t item,
	input  logic      rsp_ready,
	output logic      rsp_valid,
	output logic      rsp_in_rect,
	output logic [3:0] rsp_entry_count
);
	fte_item_t          item_q;
	logic [31:0]        region_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_q;
	logic               rd_vld_s1;
	logic               found_q;
	logic               out_valid_q;
	logic               out_in_rect_q;
	logic [3:0]         out_cnt_q;

	logic               rd_en;
	logic [ENTRY_W-1:0] rdata;
	logic signed [COORD_W-1:0] rd_col;
	logic signed [COORD_W-1:0] rd_row;
	logic               match;
	logic               do_write;
	logic [CNT_W-1:0]   cnt_next;

	assign rd_en  = cmd.scan && (idx_q < cnt_q);
	assign rd_col = rdata[ENTRY_W-1:COORD_W];
	assign rd_row = rdata[COORD_W-1:0];

	always_comb begin
		match = 1'b0;
		if (item_q.mode == MODE_ADD) begin
			match = (rd_col == item_q.tile_col) && (rd_row == item_q.tile_row);
		end else if (item_q.mode == MODE_QUERY) begin
			match = (item_q.rect_left <= rd_col) && (rd_col <= item_q.rect_right)
				&& (item_q.rect_top <= rd_row) && (rd_row <= item_q.rect_bottom);
		end
	end

	assign do_write = cmd.finish && (item_q.mode == MODE_ADD) && !found_q
		&& (cnt_q < CNT_W'(SET_ENTRIES));
	assign cnt_next = do_write ? cnt_q + 1'b1 : cnt_q;

	fte_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SET_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({item_q.tile_col, item_q.tile_row}),
		.re    (rd_en),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= item;
		end
		if (cmd.finish) begin
			out_in_rect_q <= (item_q.mode == MODE_QUERY) && (region_q == item_q.region_id)
				&& found_q;
			out_cnt_q     <= 4'(cnt_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q    <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
				found_q   <= 1'b0;
				if (item.mode == MODE_CLEAR) begin
					region_q <= '0;
					cnt_q    <= '0;
				end else if (item.mode == MODE_ADD && region_q != item.region_id) begin
					region_q <= item.region_id;
					cnt_q    <= '0;
				end
			end else begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_vld_s1 && match) begin
					found_q <= 1'b1;
				end
				cnt_q <= cnt_next;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.scan_done  = (idx_q == cnt_q) && !rd_vld_s1;
	assign sts.out_busy   = out_valid_q && !rsp_ready;
	assign rsp_valid      = out_valid_q;
	assign rsp_in_rect    = out_in_rect_q;
	assign rsp_entry_count = out_cnt_q;

	`FTE_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(SET_ENTRIES), "entry count above capacity")
	`FTE_ASSERT(a_idx_bound, idx_q <= cnt_q, "scan index past entry count")
	`FTE_ASSERT(a_no_clobber, !(cmd.finish && out_valid_q && !rsp_ready),
		"result overwritten before taken")
	`FTE_ASSERT_NEXT(a_rd_from_scan, !cmd.scan, !rd_vld_s1, "read data without a scan read")
endmodule

// ===== rtl/fte_ctrl.sv =====
module fte_ctrl import fte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output fte_cmd_t cmd,
	input  fte_sts_t sts
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} fte_state_t;

	fte_state_t state_q;
	fte_state_t state_d;

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/fired_tile_event_set.sv =====
// channel  dir  handshake          word
// req      in   req.valid/ready    mode, region_id, tile_col/row, rect_*
// rsp      out  rsp.valid/ready    in_rect, entry_count
//
// One word at a time: the accept, one RAM read per entry scanned, the registered
// read data from the RAM, an end-of-scan check, then the update and the load of
// the result register. The scan over the entry RAM grows with the entries stored.
// arst_n clears region tag, entry count and control; entry RAM is not cleared.
// A held result stalls only the final cycle of the next word.
module fired_tile_event_set import fte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	fte_req_if.sink   req,
	fte_rsp_if.source rsp
);
	fte_cmd_t  cmd;
	fte_sts_t  sts;
	fte_item_t item;

	always_comb begin
		item.mode        = req.mode;
		item.region_id   = req.region_id;
		item.tile_col    = req.tile_col;
		item.tile_row    = req.tile_row;
		item.rect_left   = req.rect_left;
		item.rect_top    = req.rect_top;
		item.rect_right  = req.rect_right;
		item.rect_bottom = req.rect_bottom;
	end

	fte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fte_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.item            (item),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_in_rect     (rsp.in_rect),
		.rsp_entry_count (rsp.entry_count)
	);
endmodule
